>>> rtl/core/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_OPCODE  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_ELENGTH = 5'b00100,
    PH_MASKKEY = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // Error codes reported in error_kind.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OPCODE   = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_RESERVED = 2'd3
  } err_e;

  localparam int unsigned LenW = 64;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] OP_CONT    = 4'h0;

  // Extended length byte counters hold bytes left minus one.
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [1:0] KEY_LAST   = 2'd3;

  // One result item.
  typedef struct packed {
    logic       message_start;
    logic [3:0] start_opcode;
    logic       data_valid;
    logic [7:0] payload_out;
    logic       message_end;
    err_e       error_kind;
  } result_t;

endpackage

>>> rtl/core/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+---------------------------------------------
//   in      | in_valid_i / in_ready_o | stream_byte_i
//   out     | out_valid_o/out_ready_i | message_start_o, start_opcode_o, data_valid_o,
//           |                         | payload_out_o, message_end_o, error_kind_o
//
// One byte in, one result out, one item per cycle sustained while out_ready_i stays high.
// An accepted byte is held in the input register, then decoded combinationally by the
// parser into the result register, which drives out_valid_o; the result is taken at a
// later edge with out_ready_i high.
// rst_ni clears the parser to await an opcode byte outside any fragmented message.
// A stall on out_ready_i holds the result register; with a byte already held in the
// input register in_ready_o falls in that same cycle, an empty input register first
// takes one more byte. in_ready_o rises again once the result is taken.
module websocket_frame_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       message_start_o,
  output logic [3:0] start_opcode_o,
  output logic       data_valid_o,
  output logic [7:0] payload_out_o,
  output logic       message_end_o,
  output logic [1:0] error_kind_o
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              out_free;
  logic              advance;
  wsfd_pkg::result_t parse_res;
  wsfd_pkg::result_t out_res;

  // Advance the held byte through the parser whenever the result register can take it.
  assign advance = s1_valid && out_free;

  wsfd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stream_byte_i(stream_byte_i),
    .advance_i    (advance),
    .valid_o      (s1_valid),
    .byte_o       (s1_byte)
  );

  // Parser state moves only on a byte that advances, so stalls leave it untouched.
  wsfd_parser u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .byte_i(s1_byte),
    .res_o (parse_res)
  );

  wsfd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (parse_res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (out_res)
  );

  // Unpack the result item onto its ports.
  assign message_start_o = out_res.message_start;
  assign start_opcode_o  = out_res.start_opcode;
  assign data_valid_o    = out_res.data_valid;
  assign payload_out_o   = out_res.payload_out;
  assign message_end_o   = out_res.message_end;
  assign error_kind_o    = out_res.error_kind;

endmodule

>>> rtl/core/wsfd_in_stage.sv
// Input register of the deframer: holds one accepted stream byte.
module wsfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // Take a new byte when empty or when the held one moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= stream_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

>>> rtl/core/wsfd_parser.sv
// Frame parser: per-stream state and the decode of one byte into a result.
module wsfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output wsfd_pkg::result_t res_o
);

  wsfd_pkg::phase_e            phase_q, phase_d;
  logic                        fin_q, fin_d;
  logic                        masked_q, masked_d;
  logic                        frag_q, frag_d;
  logic [wsfd_pkg::LenW-1:0]   len_q, len_d;
  logic [2:0]                  ext_cnt_q, ext_cnt_d;
  logic [31:0]                 key_q, key_d;
  logic [1:0]                  key_cnt_q, key_cnt_d;
  logic [1:0]                  kidx_q, kidx_d;

  logic [wsfd_pkg::LenW-1:0]   len_shift;
  logic [7:0]                  key_byte;
  wsfd_pkg::result_t           res;

  assign len_shift = {len_q[wsfd_pkg::LenW-9:0], byte_i};

  always_comb begin
    unique case (kidx_q)
      2'd0: key_byte = key_q[31:24];
      2'd1: key_byte = key_q[23:16];
      2'd2: key_byte = key_q[15:8];
      2'd3: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    logic restart;
    restart   = 1'b0;
    res       = '0;
    phase_d   = phase_q;
    fin_d     = fin_q;
    masked_d  = masked_q;
    frag_d    = frag_q;
    len_d     = len_q;
    ext_cnt_d = ext_cnt_q;
    key_d     = key_q;
    key_cnt_d = key_cnt_q;
    kidx_d    = kidx_q;

    unique case (phase_q)
      wsfd_pkg::PH_LENGTH: begin
        masked_d = byte_i[7];
        if (byte_i[6:0] >= wsfd_pkg::LEN7_EXT16) begin
          ext_cnt_d = (byte_i[6:0] == wsfd_pkg::LEN7_EXT64) ?
                      wsfd_pkg::EXT64_LAST : wsfd_pkg::EXT16_LAST;
          len_d     = '0;
          phase_d   = wsfd_pkg::PH_ELENGTH;
        end else begin
          len_d = {{(wsfd_pkg::LenW-7){1'b0}}, byte_i[6:0]};
          if (byte_i[7]) begin
            phase_d = wsfd_pkg::PH_MASKKEY;
          end else if (byte_i[6:0] != 7'd0) begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end else begin
            res.message_end = fin_q;
            restart         = 1'b1;
          end
        end
      end
      wsfd_pkg::PH_ELENGTH: begin
        len_d = len_shift;
        if (ext_cnt_q == 3'd0) begin
          priority if (len_shift[wsfd_pkg::LenW-1]) begin
            res.error_kind = wsfd_pkg::ERR_LENGTH;
            restart        = 1'b1;
          end else if (masked_q) begin
            phase_d = wsfd_pkg::PH_MASKKEY;
          end else if (len_shift != '0) begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end else begin
            res.message_end = fin_q;
            restart         = 1'b1;
          end
        end else begin
          ext_cnt_d = ext_cnt_q - 3'd1;
        end
      end
      wsfd_pkg::PH_MASKKEY: begin
        key_d = {key_q[23:0], byte_i};
        if (key_cnt_q == wsfd_pkg::KEY_LAST) begin
          if (len_q != '0) begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end else begin
            res.message_end = fin_q;
            restart         = 1'b1;
          end
        end else begin
          key_cnt_d = key_cnt_q + 2'd1;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        // len_q counts the payload bytes still to come.
        res.data_valid  = 1'b1;
        res.payload_out = byte_i ^ key_byte;
        kidx_d          = kidx_q + 2'd1;
        if (len_q == {{(wsfd_pkg::LenW-1){1'b0}}, 1'b1}) begin
          res.message_end = fin_q;
          restart         = 1'b1;
        end else begin
          len_d = len_q - {{(wsfd_pkg::LenW-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        // Opcode byte.
        fin_d = byte_i[7];
        if (!frag_q) begin
          res.message_start = 1'b1;
          res.start_opcode  = byte_i[3:0];
          phase_d           = wsfd_pkg::PH_LENGTH;
        end else if (byte_i[3:0] == wsfd_pkg::OP_CONT) begin
          phase_d = wsfd_pkg::PH_LENGTH;
        end else begin
          res.error_kind = wsfd_pkg::ERR_OPCODE;
          restart        = 1'b1;
        end
        frag_d = !byte_i[7];
      end
    endcase

    if (restart) begin
      phase_d   = wsfd_pkg::PH_OPCODE;
      fin_d     = 1'b0;
      masked_d  = 1'b0;
      len_d     = '0;
      ext_cnt_d = '0;
      key_d     = '0;
      key_cnt_d = '0;
      kidx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsfd_pkg::PH_OPCODE;
      fin_q     <= 1'b0;
      masked_q  <= 1'b0;
      frag_q    <= 1'b0;
      len_q     <= '0;
      ext_cnt_q <= '0;
      key_q     <= '0;
      key_cnt_q <= '0;
      kidx_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      masked_q  <= masked_d;
      frag_q    <= frag_d;
      len_q     <= len_d;
      ext_cnt_q <= ext_cnt_d;
      key_q     <= key_d;
      key_cnt_q <= key_cnt_d;
      kidx_q    <= kidx_d;
    end
  end

  assign res_o = res;

  // An error always sends the parser back to the opcode byte.
  a_err_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.error_kind != wsfd_pkg::ERR_NONE) |=> phase_q == wsfd_pkg::PH_OPCODE)
    else $error("parser did not restart after an error");

  // Per-frame state is clean whenever a frame header is awaited.
  a_clean_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfd_pkg::PH_OPCODE |-> (len_q == '0) && (kidx_q == '0) && (key_q == '0))
    else $error("stale frame state at opcode byte");

  // Unmasked frames pass payload bytes through unchanged.
  a_unmasked_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == wsfd_pkg::PH_PAYLOAD) && !masked_q |-> res.payload_out == byte_i)
    else $error("unmasked payload byte altered");

  // A payload phase is never entered with nothing left to deliver.
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfd_pkg::PH_PAYLOAD |-> (len_q != '0) && !len_q[wsfd_pkg::LenW-1])
    else $error("payload phase with bad remaining length");

endmodule

>>> rtl/core/wsfd_out_stage.sv
// Result register of the deframer.
module wsfd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  wsfd_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wsfd_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  wsfd_pkg::result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
